/* hdl/hsl_pkg.sv */
// Shared constants, field widths and the sine hue wheel tables for the HSL to RGB converter.
// The quarter-wave tables are built at elaboration by fixed-point integer arithmetic.
// Depends on nothing; every module of the block imports it.
package hsl_pkg;

    localparam int HUE_STEPS     = 768;
    localparam int FRAC_BITS     = 8;
    localparam int HUE_W         = 10;
    localparam int LIGHT_W       = 10;
    localparam int SAT_W         = 9;
    localparam int CH_W          = 8;
    localparam int NUM_STAGES    = 5;

    localparam int ONE           = 1 << FRAC_BITS;
    localparam int THIRD_STEPS   = HUE_STEPS / 3;
    localparam int HALF_STEPS    = HUE_STEPS / 2;
    localparam int QUARTER_STEPS = HUE_STEPS / 4;
    localparam int QIDX_W        = $clog2(QUARTER_STEPS + 1);
    localparam int CH_MAX        = (1 << CH_W) - 1;

    // Division of a channel sum (at most 765) by three: floor(x * 683 / 2048).
    localparam int AVG_MUL       = 683;
    localparam int AVG_SHIFT     = 11;
    localparam int SUM_W         = CH_W + 2;
    localparam int AVG_MUL_W     = 10;

    typedef logic [CH_W-1:0] wheel_tbl_t [0:QUARTER_STEPS];

    typedef logic [CH_W-1:0] rgb_t [0:2];

    localparam longint unsigned FX_ONE     = 64'h1000_0000_0000_0000;
    localparam longint unsigned FX_HALF    = 64'h0800_0000_0000_0000;
    localparam longint unsigned FX_PI_HALF = 64'h1921_FB54_442D_1846;
    localparam longint unsigned LOW30      = 64'h0000_0000_3FFF_FFFF;

    function automatic longint unsigned fx_mul(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned ah;
        longint unsigned al;
        longint unsigned bh;
        longint unsigned bl;
        longint unsigned mid;
        ah  = a >> 30;
        al  = a & LOW30;
        bh  = b >> 30;
        bl  = b & LOW30;
        mid = ah * bl + al * bh + ((al * bl) >> 30);
        return ah * bh + (mid >> 30);
    endfunction

    // Truncating long division by a small nonzero divisor.
    function automatic longint unsigned div_small(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        int              i;
        rem = 0;
        quo = 0;
        for (i = 63; i >= 0; i--)
        begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Sine of (pi/2 * w / t) in Q60, for 0 <= w <= t.
    function automatic longint unsigned quarter_sine(input longint unsigned w,
                                                     input longint unsigned t);
        longint unsigned r;
        longint unsigned x;
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned div;
        int              i;
        int              n;
        r = w;
        x = 0;
        if (w >= t)
        begin
            return FX_ONE;
        end
        if (w == 0)
        begin
            return 0;
        end
        if (3 * w == t)
        begin
            return FX_HALF;
        end
        for (i = 0; i < 60; i++)
        begin
            r = r << 1;
            x = x << 1;
            if (r >= t)
            begin
                r = r - t;
                x = x | 64'd1;
            end
        end
        theta = fx_mul(x, FX_PI_HALF);
        t2    = fx_mul(theta, theta);
        sum   = theta;
        term  = theta;
        for (n = 1; n <= 20; n++)
        begin
            if (term != 0)
            begin
                div  = longint'(2 * n) * longint'(2 * n + 1);
                term = div_small(fx_mul(term, t2), div);
                if ((n % 2) == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        return (sum > FX_ONE) ? FX_ONE : sum;
    endfunction

    function automatic logic [CH_W-1:0] scale255(input longint unsigned v);
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned res;
        hi  = v >> 30;
        lo  = v & LOW30;
        res = (255 * hi + ((255 * lo) >> 30)) >> 30;
        return res[CH_W-1:0];
    endfunction

    // Pure channel at phase a, counted in thirds of a hue step.
    function automatic logic [CH_W-1:0] wheel_value(input longint unsigned a);
        longint unsigned turn;
        longint unsigned w;
        longint unsigned s;
        longint unsigned v;
        logic            neg;
        turn = 3 * HUE_STEPS;
        w    = 4 * a;
        neg  = 1'b0;
        if (w >= 2 * turn)
        begin
            neg = 1'b1;
            w   = w - 2 * turn;
        end
        if (w > turn)
        begin
            w = 2 * turn - w;
        end
        s = quarter_sine(w, turn);
        if (!neg)
        begin
            v = s + FX_HALF;
            return (v >= FX_ONE) ? CH_W'(CH_MAX) : scale255(v);
        end
        if (s >= FX_HALF)
        begin
            return '0;
        end
        return scale255(FX_HALF - s);
    endfunction

    function automatic wheel_tbl_t build_wheel_tbl(input logic neg);
        wheel_tbl_t tbl;
        int         q;
        for (q = 0; q <= QUARTER_STEPS; q++)
        begin
            tbl[q] = wheel_value(longint'(3 * (q + (neg ? HALF_STEPS : 0))));
        end
        return tbl;
    endfunction

    localparam wheel_tbl_t POS_TBL = build_wheel_tbl(1'b0);
    localparam wheel_tbl_t NEG_TBL = build_wheel_tbl(1'b1);

endpackage

/* hdl/hsl_wheel.sv */
// Sine hue wheel lookup: folds a wheel position onto a quarter wave and reads the tables.
// Depends on hsl_pkg for the tables and widths.
module hsl_wheel
    import hsl_pkg::*;
(
    input  logic [HUE_W-1:0] pos,
    output logic [CH_W-1:0]  value
);

    logic              upper_half;
    logic [HUE_W-1:0]  half_pos;
    logic [HUE_W-1:0]  folded;

    always_comb
    begin
        upper_half = (pos >= HUE_W'(HALF_STEPS));
        half_pos   = upper_half ? (pos - HUE_W'(HALF_STEPS)) : pos;
        folded     = (half_pos > HUE_W'(QUARTER_STEPS)) ?
                     (HUE_W'(HALF_STEPS) - half_pos) : half_pos;
        value      = upper_half ? NEG_TBL[folded[QIDX_W-1:0]] : POS_TBL[folded[QIDX_W-1:0]];
    end

endmodule

/* hdl/hue_lightness_saturation_to_rgb_top.sv */
// Top level of the HSL to RGB converter with a sine hue wheel.
// Depends on hsl_pkg and hsl_wheel.
//
// The converter takes one beat per clock while input ready is high and returns one result
// beat for each input beat, in order. The five register stages are: input clamp and hue wrap,
// hue wheel lookup, lightness, channel average and saturation products, and the final mix
// that also serves as the output register. A stall on the output holds every stage that is
// full and lets empty stages fill, so input ready falls only when the whole pipeline is full
// and the output beat is not taken.
module hue_lightness_saturation_to_rgb_top
    import hsl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [HUE_W-1:0]          hue,
    input  logic signed [LIGHT_W-1:0] lightness,
    input  logic [SAT_W-1:0]          saturation,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CH_W-1:0]           hue_red,
    output logic [CH_W-1:0]           hue_green,
    output logic [CH_W-1:0]           hue_blue,
    output logic [CH_W-1:0]           out_red,
    output logic [CH_W-1:0]           out_green,
    output logic [CH_W-1:0]           out_blue
);

    localparam int PROD_W = CH_W + SAT_W;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] adv;

    // Stage 1: clamped inputs.
    logic [HUE_W-1:0]          s1_hue_reg;
    logic [HUE_W-1:0]          s1_hue_next;
    logic signed [LIGHT_W-1:0] s1_light_reg;
    logic signed [LIGHT_W-1:0] s1_light_next;
    logic [SAT_W-1:0]          s1_sat_reg;
    logic [SAT_W-1:0]          s1_sat_next;

    // Stage 2: pure hue channels.
    logic [HUE_W:0]            pos_sum [0:2];
    logic [HUE_W-1:0]          pos [0:2];
    rgb_t                      s2_ch_next;
    rgb_t                      s2_ch_reg;
    logic signed [LIGHT_W-1:0] s2_light_reg;
    logic [SAT_W-1:0]          s2_sat_reg;

    // Stage 3: lightness applied.
    logic                      light_pos;
    logic [SAT_W-1:0]          light_mul;
    logic [CH_W-1:0]           light_base [0:2];
    logic [PROD_W-1:0]         light_prod [0:2];
    rgb_t                      s3_adj_next;
    rgb_t                      s3_adj_reg;
    rgb_t                      s3_ch_reg;
    logic [SAT_W-1:0]          s3_sat_reg;

    // Stage 4: channel average and saturation products.
    logic [SUM_W-1:0]          ch_sum;
    logic [SUM_W+AVG_MUL_W-1:0] avg_prod;
    logic [PROD_W-1:0]         sat_prod [0:2];
    logic [CH_W-1:0]           s4_avg_next;
    logic [CH_W-1:0]           s4_avg_reg;
    rgb_t                      s4_part_next;
    rgb_t                      s4_part_reg;
    rgb_t                      s4_ch_reg;
    logic [SAT_W-1:0]          s4_sat_reg;

    // Stage 5: final mix, output register.
    logic [SAT_W-1:0]          desat;
    logic [PROD_W-1:0]         gray_prod;
    logic [CH_W:0]             mix [0:2];
    rgb_t                      s5_out_next;
    rgb_t                      s5_out_reg;
    rgb_t                      s5_ch_reg;

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        s1_hue_next = (hue >= HUE_W'(HUE_STEPS)) ? (hue - HUE_W'(HUE_STEPS)) : hue;
        if (lightness > LIGHT_W'(ONE))
        begin
            s1_light_next = LIGHT_W'(ONE);
        end
        else if (lightness < -LIGHT_W'(ONE))
        begin
            s1_light_next = -LIGHT_W'(ONE);
        end
        else
        begin
            s1_light_next = lightness;
        end
        s1_sat_next = (saturation > SAT_W'(ONE)) ? SAT_W'(ONE) : saturation;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            s1_hue_reg   <= s1_hue_next;
            s1_light_reg <= s1_light_next;
            s1_sat_reg   <= s1_sat_next;
        end
    end

    // Red sits a third of a turn ahead of blue, green two thirds.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pos_sum[c] = {1'b0, s1_hue_reg}
                         + (HUE_W + 1)'((c == 2) ? 0 : (c + 1) * THIRD_STEPS);
            pos[c]     = (pos_sum[c] >= (HUE_W + 1)'(HUE_STEPS)) ?
                         HUE_W'(pos_sum[c] - (HUE_W + 1)'(HUE_STEPS)) : pos_sum[c][HUE_W-1:0];
        end
    end

    hsl_wheel u_wheel_red
    (
        .pos   (pos[0]),
        .value (s2_ch_next[0])
    );

    hsl_wheel u_wheel_green
    (
        .pos   (pos[1]),
        .value (s2_ch_next[1])
    );

    hsl_wheel u_wheel_blue
    (
        .pos   (pos[2]),
        .value (s2_ch_next[2])
    );

    always_ff @(posedge clk)
    begin
        if (adv[1] && vld_reg[0])
        begin
            s2_ch_reg    <= s2_ch_next;
            s2_light_reg <= s1_light_reg;
            s2_sat_reg   <= s1_sat_reg;
        end
    end

    // Positive lightness blends toward full scale, otherwise the channel is scaled down.
    always_comb
    begin
        light_pos = (s2_light_reg > 0);
        light_mul = light_pos ? s2_light_reg[SAT_W-1:0]
                              : SAT_W'(LIGHT_W'(ONE) + s2_light_reg);
        for (int c = 0; c < 3; c++)
        begin
            light_base[c] = light_pos ? (CH_W'(CH_MAX) - s2_ch_reg[c]) : s2_ch_reg[c];
            light_prod[c] = PROD_W'(light_base[c]) * PROD_W'(light_mul);
            s3_adj_next[c] = light_pos ?
                             (s2_ch_reg[c] + light_prod[c][FRAC_BITS +: CH_W]) :
                             light_prod[c][FRAC_BITS +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2] && vld_reg[1])
        begin
            s3_adj_reg <= s3_adj_next;
            s3_ch_reg  <= s2_ch_reg;
            s3_sat_reg <= s2_sat_reg;
        end
    end

    always_comb
    begin
        ch_sum   = SUM_W'(s3_adj_reg[0]) + SUM_W'(s3_adj_reg[1]) + SUM_W'(s3_adj_reg[2]);
        avg_prod = (SUM_W + AVG_MUL_W)'(ch_sum) * (SUM_W + AVG_MUL_W)'(AVG_MUL);
        s4_avg_next = avg_prod[AVG_SHIFT +: CH_W];
        for (int c = 0; c < 3; c++)
        begin
            sat_prod[c]     = PROD_W'(s3_adj_reg[c]) * PROD_W'(s3_sat_reg);
            s4_part_next[c] = sat_prod[c][FRAC_BITS +: CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3] && vld_reg[2])
        begin
            s4_avg_reg  <= s4_avg_next;
            s4_part_reg <= s4_part_next;
            s4_ch_reg   <= s3_ch_reg;
            s4_sat_reg  <= s3_sat_reg;
        end
    end

    always_comb
    begin
        desat     = SAT_W'(ONE) - s4_sat_reg;
        gray_prod = PROD_W'(s4_avg_reg) * PROD_W'(desat);
        for (int c = 0; c < 3; c++)
        begin
            mix[c]         = {1'b0, s4_part_reg[c]} + {1'b0, gray_prod[FRAC_BITS +: CH_W]};
            s5_out_next[c] = mix[c][CH_W] ? CH_W'(CH_MAX) : mix[c][CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4] && vld_reg[3])
        begin
            s5_out_reg <= s5_out_next;
            s5_ch_reg  <= s4_ch_reg;
        end
    end

    assign hue_red   = s5_ch_reg[0];
    assign hue_green = s5_ch_reg[1];
    assign hue_blue  = s5_ch_reg[2];
    assign out_red   = s5_out_reg[0];
    assign out_green = s5_out_reg[1];
    assign out_blue  = s5_out_reg[2];

endmodule

/* hdl/hsl_checker.sv */
// Port-level checks for the HSL to RGB converter, bound to its top level.
// Depends on hsl_pkg for the field widths.
module hsl_checker
    import hsl_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] hue_red,
    input logic [CH_W-1:0] hue_green,
    input logic [CH_W-1:0] hue_blue,
    input logic [CH_W-1:0] out_red,
    input logic [CH_W-1:0] out_green,
    input logic [CH_W-1:0] out_blue
);

    // A stalled output beat stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its output channels and its red hue channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
                                    && $stable(out_blue) && $stable(hue_red))
        else $error("output payload changed while stalled");

    // The pipeline refuses input only when it is backed up at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back pressure");

    // Three phases a third of a turn apart always put one channel at full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue_red == CH_W'(CH_MAX) || hue_green == CH_W'(CH_MAX)
                      || hue_blue == CH_W'(CH_MAX))
        else $error("pure hue color has no channel at full scale");

endmodule

bind hue_lightness_saturation_to_rgb_top hsl_checker u_hsl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hue_red   (hue_red),
    .hue_green (hue_green),
    .hue_blue  (hue_blue),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
);

/* tb/tb_hue_lightness_saturation_to_rgb_top.sv */
// Self-checking testbench for the HSL to RGB converter with a sine hue wheel.
// Random handshake stalls on both sides, with results checked against a local color predictor.
// Depends on hsl_pkg and hue_lightness_saturation_to_rgb_top.
module tb_hue_lightness_saturation_to_rgb_top;
    import hsl_pkg::*;

    typedef struct {
        logic [HUE_W-1:0]          hue;
        logic signed [LIGHT_W-1:0] light;
        logic [SAT_W-1:0]          sat;
        bit                        drain;
    } hsl_beat_t;

    typedef struct {
        logic [CH_W-1:0] hue_r;
        logic [CH_W-1:0] hue_g;
        logic [CH_W-1:0] hue_b;
        logic [CH_W-1:0] adj_r;
        logic [CH_W-1:0] adj_g;
        logic [CH_W-1:0] adj_b;
    } rgb_pair_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [HUE_W-1:0]          hue = '0;
    logic signed [LIGHT_W-1:0] lightness = '0;
    logic [SAT_W-1:0]          saturation = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CH_W-1:0]           hue_red;
    logic [CH_W-1:0]           hue_green;
    logic [CH_W-1:0]           hue_blue;
    logic [CH_W-1:0]           out_red;
    logic [CH_W-1:0]           out_green;
    logic [CH_W-1:0]           out_blue;

    hsl_beat_t beat_q[$];
    rgb_pair_t color_q[$];
    logic      in_taken = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        calm_in = 1'b0;
    bit        calm_out = 1'b0;
    int        errors = 0;
    int        beats_in = 0;
    int        results_seen = 0;
    int        wrapped_hues = 0;
    int        clamped_levels = 0;

    hue_lightness_saturation_to_rgb_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .lightness  (lightness),
        .saturation (saturation),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue_red    (hue_red),
        .hue_green  (hue_green),
        .hue_blue   (hue_blue),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue)
    );

    always #2 clk = ~clk;

    // Phase is counted in thirds of a hue step. Multiples of thirty degrees whose sine is
    // 0, 1/2 or 1 in magnitude are taken exactly.
    function automatic int sine_channel(input int phase);
        int  turn;
        int  sector;
        real s;
        real c;
        turn   = 3 * HUE_STEPS;
        sector = turn / 12;
        s      = $sin(6.283185307179586 * phase / turn);
        if (phase % sector == 0)
        begin
            case (phase / sector)
                0, 6:  s = 0.0;
                1, 5:  s = 0.5;
                3:     s = 1.0;
                7, 11: s = -0.5;
                9:     s = -1.0;
                default: ;
            endcase
        end
        c = s + 0.5;
        if (c > 1.0)
        begin
            c = 1.0;
        end
        if (c < 0.0)
        begin
            c = 0.0;
        end
        return int'($floor(255.0 * c));
    endfunction

    function automatic rgb_pair_t convert_hsl(input logic [HUE_W-1:0] h,
                                              input logic signed [LIGHT_W-1:0] lt,
                                              input logic [SAT_W-1:0] st);
        rgb_pair_t res;
        int        turn;
        int        base;
        int        l;
        int        s;
        int        ch[3];
        int        adj[3];
        int        avg;
        int        mix;
        int        v;
        turn = 3 * HUE_STEPS;
        base = 3 * (int'(h) % HUE_STEPS);
        l    = lt;
        s    = st;
        if (l > ONE)
        begin
            l = ONE;
        end
        if (l < -ONE)
        begin
            l = -ONE;
        end
        if (s > ONE)
        begin
            s = ONE;
        end
        ch[0] = sine_channel((base + HUE_STEPS) % turn);
        ch[1] = sine_channel((base + 2 * HUE_STEPS) % turn);
        ch[2] = sine_channel(base);
        for (int i = 0; i < 3; i++)
        begin
            if (l > 0)
            begin
                adj[i] = ch[i] + (((CH_MAX - ch[i]) * l) >>> FRAC_BITS);
            end
            else
            begin
                adj[i] = (ch[i] * (ONE + l)) >>> FRAC_BITS;
            end
        end
        avg = (adj[0] + adj[1] + adj[2]) / 3;
        mix = (avg * (ONE - s)) >>> FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            v      = ((adj[i] * s) >>> FRAC_BITS) + mix;
            adj[i] = (v > CH_MAX) ? CH_MAX : v;
        end
        res.hue_r = CH_W'(ch[0]);
        res.hue_g = CH_W'(ch[1]);
        res.hue_b = CH_W'(ch[2]);
        res.adj_r = CH_W'(adj[0]);
        res.adj_g = CH_W'(adj[1]);
        res.adj_b = CH_W'(adj[2]);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 95)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic add_beat(input int h, input int l, input int s);
        hsl_beat_t b;
        b.hue   = HUE_W'(h);
        b.light = LIGHT_W'(l);
        b.sat   = SAT_W'(s);
        b.drain = 1'b0;
        beat_q.push_back(b);
    endtask

    task automatic add_drain();
        hsl_beat_t b;
        b.hue   = '0;
        b.light = '0;
        b.sat   = '0;
        b.drain = 1'b1;
        beat_q.push_back(b);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(negedge clk)
    begin : drive_input
        hsl_beat_t b;
        logic      next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_taken))
        begin
            next_valid = 1'b0;
            if (in_taken)
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    calm_in = ~calm_in;
                end
                send_gap = (!calm_in && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (beat_q.size() > 0)
            begin
                if (beat_q[0].drain)
                begin
                    if (color_q.size() == 0)
                    begin
                        void'(beat_q.pop_front());
                    end
                end
                else
                begin
                    b          = beat_q.pop_front();
                    hue        <= b.hue;
                    lightness  <= b.light;
                    saturation <= b.sat;
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
            begin
                calm_out = ~calm_out;
            end
            if (!calm_out && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : watch_ports
        rgb_pair_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            color_q.push_back(convert_hsl(hue, lightness, saturation));
            beats_in++;
            if (hue >= HUE_STEPS)
            begin
                wrapped_hues++;
            end
            if (lightness > ONE || lightness < -ONE || saturation > ONE)
            begin
                clamped_levels++;
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (color_q.size() == 0)
            begin
                $display("[%0t] result beat with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = color_q.pop_front();
                if (hue_red !== want.hue_r)
                begin
                    report_mismatch("hue_red", hue_red, want.hue_r);
                end
                if (hue_green !== want.hue_g)
                begin
                    report_mismatch("hue_green", hue_green, want.hue_g);
                end
                if (hue_blue !== want.hue_b)
                begin
                    report_mismatch("hue_blue", hue_blue, want.hue_b);
                end
                if (out_red !== want.adj_r)
                begin
                    report_mismatch("out_red", out_red, want.adj_r);
                end
                if (out_green !== want.adj_g)
                begin
                    report_mismatch("out_green", out_green, want.adj_g);
                end
                if (out_blue !== want.adj_b)
                begin
                    report_mismatch("out_blue", out_blue, want.adj_b);
                end
            end
        end
    end

    initial
    begin
        int r;
        int l;
        int s;
        add_beat(0, 0, 256);
        add_beat(1023, 0, 256);
        add_beat(767, 0, 256);
        add_beat(768, 0, 256);
        add_beat(64, 0, 256);
        add_beat(192, 0, 256);
        add_beat(320, 0, 256);
        add_beat(448, 0, 256);
        add_beat(576, 0, 256);
        add_beat(100, 256, 256);
        add_beat(100, -256, 256);
        add_beat(100, 511, 0);
        add_beat(100, -512, 0);
        add_beat(100, 257, 128);
        add_beat(100, -257, 128);
        add_beat(300, 1, 511);
        add_beat(300, -1, 257);
        add_beat(500, 128, 0);
        add_beat(500, -128, 256);
        add_beat(700, 255, 300);
        add_beat(40, -255, 255);
        add_drain();
        for (int i = 0; i < 1400; i++)
        begin
            if (i % 350 == 349)
            begin
                add_drain();
            end
            r = $urandom_range(0, 99);
            l = (r < 70) ? int'($urandom_range(0, 512)) - 256 : int'($urandom_range(0, 1023));
            r = $urandom_range(0, 99);
            s = (r < 70) ? $urandom_range(0, 256) : $urandom_range(0, 511);
            add_beat($urandom_range(0, 1023), l, s);
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (beat_q.size() > 0 || in_valid || color_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d beats and checked %0d result beats.", beats_in, results_seen);
        $display("Hue wrap beats: %0d, beats with lightness or saturation clamped: %0d.",
                 wrapped_hues, clamped_levels);
        if (errors == 0 && color_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out waiting for the converter.");
        $display("Regression FAIL");
        $finish;
    end

endmodule
